// ----- hw/rtl/kws_pkg.sv -----
// shared types, constants and helpers for the keyword substitution cipher
// no dependencies; imported by kws_sched, kws_lookup and the top level
`default_nettype none

package kws_pkg;

  localparam int AlphaCount = 26;
  localparam int IdxW       = $clog2(AlphaCount);

  localparam logic [7:0] LetterA = 8'h61;
  localparam logic [7:0] LetterZ = 8'h7A;

  typedef logic [IdxW-1:0]       idx_t;
  typedef logic [AlphaCount-1:0] alpha_t;

  typedef enum logic [1:0] {
    REQ_KEY = 2'd0,
    REQ_ENC = 2'd1,
    REQ_DEC = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_DRAIN,
    ST_INV,
    ST_INV_WB
  } state_t;

  // one ram write port
  typedef struct packed {
    logic we;
    idx_t addr;
    idx_t data;
  } wr_t;

  // one ram read port
  typedef struct packed {
    logic re;
    idx_t addr;
  } rd_t;

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= LetterA) && (c <= LetterZ);
  endfunction

  function automatic idx_t letter_idx(input logic [7:0] c);
    logic [7:0] d;
    d = c - LetterA;
    return d[IdxW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/kws_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module kws_ram #(
  parameter int Width = 5,
  parameter int Depth = 26
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/kws_sched.sv -----
// key schedule: places key letters, appends unused letters, rebuilds the inverse table
// depends on kws_pkg; drives the write ports of both table rams
`default_nettype none

module kws_sched
  import kws_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   key_go,
  input  wire logic [7:0] key_char,
  input  wire logic   key_last,
  input  wire logic   lookup_busy,
  input  wire idx_t   cipher_rdata,
  output logic        idle,
  output wr_t         cipher_wr,
  output wr_t         inverse_wr,
  output rd_t         cipher_rd,
  output alpha_t      cipher_valid,
  output alpha_t      inverse_valid
);

  state_t state_r, state_nxt;
  alpha_t used_r, used_nxt;
  idx_t   fill_r, fill_nxt;
  logic   key_open_r, key_open_nxt;
  idx_t   cnt_r, cnt_nxt;
  logic   inv_we_r, inv_we_nxt;
  idx_t   inv_data_r, inv_data_nxt;
  alpha_t cvalid_r, ivalid_r;

  alpha_t used_eff;
  idx_t   fill_eff;
  idx_t   kidx;
  logic   place;
  logic   room;

  localparam idx_t LastIdx = idx_t'(AlphaCount - 1);
  localparam idx_t FullCnt = idx_t'(AlphaCount);

  // a key byte after a finished key starts from an empty alphabet
  assign used_eff = key_open_r ? used_r : '0;
  assign fill_eff = key_open_r ? fill_r : '0;
  assign kidx     = letter_idx(key_char);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (key_go && key_last) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (cnt_r == LastIdx) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!lookup_busy) begin
          state_nxt = ST_INV;
        end
      end
      ST_INV: begin
        if (cnt_r == LastIdx) begin
          state_nxt = ST_INV_WB;
        end
      end
      ST_INV_WB: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    used_nxt     = used_r;
    fill_nxt     = fill_r;
    key_open_nxt = key_open_r;
    cnt_nxt      = cnt_r;
    inv_we_nxt   = 1'b0;
    inv_data_nxt = inv_data_r;
    cipher_wr    = '0;
    cipher_rd    = '0;
    place        = 1'b0;
    room         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (key_go) begin
          place        = is_lower(key_char) && !used_eff[kidx];
          room         = fill_eff < FullCnt;
          cipher_wr.we   = place && room;
          cipher_wr.addr = fill_eff;
          cipher_wr.data = kidx;
          used_nxt     = place ? (used_eff | (alpha_t'(1) << kidx)) : used_eff;
          fill_nxt     = (place && room) ? fill_eff + idx_t'(1) : fill_eff;
          key_open_nxt = !key_last;
        end
      end
      ST_FILL: begin
        place          = !used_r[cnt_r];
        room           = fill_r < FullCnt;
        cipher_wr.we   = place && room;
        cipher_wr.addr = fill_r;
        cipher_wr.data = cnt_r;
        fill_nxt       = (place && room) ? fill_r + idx_t'(1) : fill_r;
        cnt_nxt        = (cnt_r == LastIdx) ? '0 : cnt_r + idx_t'(1);
      end
      ST_DRAIN: begin
        cnt_nxt = '0;
      end
      ST_INV: begin
        // read cipher entry now, write its inverse next cycle
        cipher_rd.re   = 1'b1;
        cipher_rd.addr = cnt_r;
        inv_we_nxt     = 1'b1;
        inv_data_nxt   = cnt_r;
        cnt_nxt        = (cnt_r == LastIdx) ? '0 : cnt_r + idx_t'(1);
      end
      ST_INV_WB: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  assign inverse_wr.we   = inv_we_r;
  assign inverse_wr.addr = cipher_rdata;
  assign inverse_wr.data = inv_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      used_r     <= '0;
      fill_r     <= '0;
      key_open_r <= 1'b0;
      cnt_r      <= '0;
      inv_we_r   <= 1'b0;
      cvalid_r   <= '0;
      ivalid_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      fill_r     <= fill_nxt;
      key_open_r <= key_open_nxt;
      cnt_r      <= cnt_nxt;
      inv_we_r   <= inv_we_nxt;
      if (cipher_wr.we) begin
        cvalid_r[cipher_wr.addr] <= 1'b1;
      end
      if (inverse_wr.we) begin
        ivalid_r[inverse_wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    inv_data_r <= inv_data_nxt;
  end

  assign idle          = (state_r == ST_IDLE);
  assign cipher_valid  = cvalid_r;
  assign inverse_valid = ivalid_r;

endmodule

`default_nettype wire

// ----- hw/rtl/kws_lookup.sv -----
// encrypt/decrypt path: table read stage followed by the output register
// depends on kws_pkg; reads both table rams through the top level
`default_nettype none

module kws_lookup
  import kws_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       issue,
  input  wire logic       issue_dec,
  input  wire logic [7:0] issue_char,
  input  wire alpha_t     cipher_valid,
  input  wire alpha_t     inverse_valid,
  input  wire idx_t       cipher_rdata,
  input  wire idx_t       inverse_rdata,
  output rd_t             table_rd,
  output logic            busy,
  output logic            can_issue,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata
);

  logic       p_valid_r, p_valid_nxt;
  logic [7:0] p_char_r;
  logic       p_lower_r;
  logic       p_dec_r;
  logic       p_ok_r;
  idx_t       p_idx_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r;

  logic       p_move;
  logic       lower;
  idx_t       idx;
  idx_t       mapped;
  logic [7:0] result;

  assign lower = is_lower(issue_char);
  assign idx   = letter_idx(issue_char);

  assign table_rd.re   = issue && lower;
  assign table_rd.addr = idx;

  assign p_move    = !out_valid_r || out_tready;
  assign can_issue = !p_valid_r || p_move;
  assign busy      = p_valid_r;

  // entries never written are read as the identity mapping, by way of the valid bits
  always_comb begin
    if (!p_ok_r) begin
      mapped = p_idx_r;
    end else if (p_dec_r) begin
      mapped = inverse_rdata;
    end else begin
      mapped = cipher_rdata;
    end
    result = p_lower_r ? (LetterA + {{(8-IdxW){1'b0}}, mapped}) : p_char_r;
  end

  assign p_valid_nxt   = issue ? 1'b1 : (p_move ? 1'b0 : p_valid_r);
  assign out_valid_nxt = p_move ? p_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_char_r  <= issue_char;
      p_lower_r <= lower;
      p_dec_r   <= issue_dec;
      p_idx_r   <= idx;
      p_ok_r    <= issue_dec ? inverse_valid[idx] : cipher_valid[idx];
    end
    if (p_valid_r && p_move) begin
      out_char_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;

endmodule

`default_nettype wire

// ----- hw/rtl/keyword_substitution_cipher.sv -----
// top level of the keyword substitution cipher: stream ports, table rams, schedule, lookup
// depends on kws_pkg, kws_ram, kws_sched and kws_lookup
`default_nettype none

// Byte stream cipher with a keyword-built alphabet. Each input transaction carries a
// byte in in_tdata and a request kind in in_tuser (key, encrypt, decrypt; the fourth
// code is accepted and dropped). Encrypt and decrypt bytes are taken one per cycle
// while in_tready is high and each yields one output transaction through the table
// read stage and the output register; lowercase letters map through the cipher or
// inverse table, every other byte comes back unchanged. Key bytes are also taken one
// per cycle while in_tready is high and give no output. The key byte with in_tlast
// set finishes the key: in_tready then stays low while the unused-letter slots are
// swept, the lookup stage drains and the inverse table is rebuilt one entry per cycle
// through the cipher ram's single read port, the last entry written back at the end.
// Both tables come out of reset as the identity mapping; no clearing pass is needed.
module keyword_substitution_cipher
  import kws_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_char
  input  wire logic [1:0] in_tuser,   // [1:0] req_type
  input  wire logic       in_tlast,   // key_last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [7:0] out_char
);

  logic   accept;
  logic   key_go;
  logic   issue;
  logic   sched_idle;
  logic   can_issue;
  logic   lookup_busy;
  req_t   req;
  wr_t    cipher_wr, inverse_wr;
  rd_t    sched_rd, lookup_rd, cipher_rd;
  alpha_t cipher_valid, inverse_valid;
  idx_t   cipher_rdata, inverse_rdata;

  assign req       = req_t'(in_tuser);
  assign in_tready = sched_idle && can_issue;
  assign accept    = in_tvalid && in_tready;
  assign key_go    = accept && (req == REQ_KEY);
  assign issue     = accept && ((req == REQ_ENC) || (req == REQ_DEC));

  // schedule reads the cipher ram only while no lookup can be issued
  assign cipher_rd = sched_rd.re ? sched_rd : lookup_rd;

  kws_ram #(
    .Width (IdxW),
    .Depth (AlphaCount)
  ) u_cipher_ram (
    .clk   (clk),
    .we    (cipher_wr.we),
    .waddr (cipher_wr.addr),
    .wdata (cipher_wr.data),
    .re    (cipher_rd.re),
    .raddr (cipher_rd.addr),
    .rdata (cipher_rdata)
  );

  kws_ram #(
    .Width (IdxW),
    .Depth (AlphaCount)
  ) u_inverse_ram (
    .clk   (clk),
    .we    (inverse_wr.we),
    .waddr (inverse_wr.addr),
    .wdata (inverse_wr.data),
    .re    (lookup_rd.re),
    .raddr (lookup_rd.addr),
    .rdata (inverse_rdata)
  );

  kws_sched u_sched (
    .clk           (clk),
    .rst_n         (rst_n),
    .key_go        (key_go),
    .key_char      (in_tdata),
    .key_last      (in_tlast),
    .lookup_busy   (lookup_busy),
    .cipher_rdata  (cipher_rdata),
    .idle          (sched_idle),
    .cipher_wr     (cipher_wr),
    .inverse_wr    (inverse_wr),
    .cipher_rd     (sched_rd),
    .cipher_valid  (cipher_valid),
    .inverse_valid (inverse_valid)
  );

  kws_lookup u_lookup (
    .clk           (clk),
    .rst_n         (rst_n),
    .issue         (issue),
    .issue_dec     (req == REQ_DEC),
    .issue_char    (in_tdata),
    .cipher_valid  (cipher_valid),
    .inverse_valid (inverse_valid),
    .cipher_rdata  (cipher_rdata),
    .inverse_rdata (inverse_rdata),
    .table_rd      (lookup_rd),
    .busy          (lookup_busy),
    .can_issue     (can_issue),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata)
  );

endmodule

`default_nettype wire
